@@ hdl/npd_pkg.sv @@
`timescale 1ns / 1ps
// npd_pkg: shared constants, codes and controller/datapath interface types
// for the nearest point distance block. No dependencies.
package npd_pkg;

	localparam int MAX_POINTS = 1024;
	localparam int ADDR_W     = $clog2(MAX_POINTS);
	localparam int CNT_W      = ADDR_W + 1;
	localparam int COORD_W    = 16;
	localparam int MAG_W      = COORD_W;        // |a - b| of two coords
	localparam int SQ_W       = 2 * MAG_W;
	localparam int SUM_W      = SQ_W + 2;       // sum of three squares
	localparam int ROOT_W     = SUM_W / 2;
	localparam int REM_W      = ROOT_W + 2;
	localparam int ITER_W     = $clog2(ROOT_W);
	localparam int PT_W       = 3 * COORD_W;
	localparam int REQ_W      = 2;
	localparam int STAT_W     = 2;
	localparam int DIST_W     = 18;

	localparam logic [REQ_W-1:0] REQ_APPEND = 2'd0;
	localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic accept;       // input transfer this cycle
		logic scan_issue;   // read one stored point
		logic root_start;   // launch square root on best_q
		logic finish;       // load the output register
	} npd_cmd_t;

	typedef struct packed {
		logic count_zero;
		logic last_issue;   // scan index is at the last stored point
		logic pipe_busy;
		logic root_done;
		logic out_free;
	} npd_stat_t;

endpackage

@@ hdl/npd_sqrt.sv @@
`timescale 1ns / 1ps
// npd_sqrt: iterative integer square root, one result bit per cycle.
// Depends on npd_pkg.
module npd_sqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [npd_pkg::SUM_W-1:0]  radicand,
	output logic                       done,
	output logic [npd_pkg::ROOT_W-1:0] root
);
	import npd_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [ITER_W-1:0] iter_q;
	logic [SUM_W-1:0]  val_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [REM_W-1:0]  rem_sh;
	logic [REM_W-1:0]  trial;
	logic              ge;

	// remainder stays below 2^(ROOT_W) before the shift, so the top bits drop safely
	assign rem_sh = {rem_q[REM_W-3:0], val_q[SUM_W-1 -: 2]};
	assign trial  = {root_q, 2'b01};
	assign ge     = (rem_sh >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				iter_q <= '0;
			end else if (busy_q) begin
				iter_q <= iter_q + 1'b1;
				if (iter_q == ITER_W'(ROOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			val_q  <= {val_q[SUM_W-3:0], 2'b00};
			rem_q  <= ge ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[ROOT_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

@@ hdl/npd_ctrl.sv @@
`timescale 1ns / 1ps
// npd_ctrl: sequencer for append, clear and query scan / root / result.
// Depends on npd_pkg.
module npd_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic [npd_pkg::REQ_W-1:0] req_type,
	input  npd_pkg::npd_stat_t        stat,
	output npd_pkg::npd_cmd_t         cmd,
	output logic                      in_stall
);
	import npd_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_SCAN  = 5'b00010,
		S_DRAIN = 5'b00100,
		S_ROOT  = 5'b01000,
		S_DONE  = 5'b10000
	} npd_state_t;

	npd_state_t state_q, state_d;

	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		case (state_q)
			S_IDLE: begin
				cmd.accept = in_valid;
				if (in_valid) begin
					if (req_type == REQ_QUERY && !stat.count_zero)
						state_d = S_SCAN;
					else
						state_d = S_DONE;
				end
			end
			S_SCAN: begin
				cmd.scan_issue = 1'b1;
				if (stat.last_issue)
					state_d = S_DRAIN;
			end
			S_DRAIN: begin
				if (!stat.pipe_busy) begin
					cmd.root_start = 1'b1;
					state_d        = S_ROOT;
				end
			end
			S_ROOT: begin
				if (stat.root_done)
					state_d = S_DONE;
			end
			S_DONE: begin
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	assign in_stall = (state_q != S_IDLE);

endmodule

@@ hdl/npd_dpath.sv @@
`timescale 1ns / 1ps
// npd_dpath: point memory, scan pipeline, running minimum, square root
// and output register. Depends on npd_pkg and npd_sqrt.
module npd_dpath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  npd_pkg::npd_cmd_t                  cmd,
	output npd_pkg::npd_stat_t                 stat,
	input  logic        [npd_pkg::REQ_W-1:0]   req_type,
	input  logic signed [npd_pkg::COORD_W-1:0] x_coord,
	input  logic signed [npd_pkg::COORD_W-1:0] y_coord,
	input  logic signed [npd_pkg::COORD_W-1:0] z_coord,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic        [npd_pkg::DIST_W-1:0]  distance,
	output logic        [npd_pkg::STAT_W-1:0]  status,
	output logic        [npd_pkg::CNT_W-1:0]   point_total
);
	import npd_pkg::*;

	logic [PT_W-1:0]    mem [MAX_POINTS];

	logic [CNT_W-1:0]   count_q;
	logic [ADDR_W-1:0]  scan_idx_q;
	logic [COORD_W-1:0] qx_q, qy_q, qz_q;
	logic [STAT_W-1:0]  pend_stat_q;
	logic [ROOT_W-1:0]  pend_dist_q;

	logic               v_s1, v_s2, v_s3;
	logic               first_s1, first_s2, first_s3;
	logic [PT_W-1:0]    pt_s1;
	logic [MAG_W-1:0]   ax_s2, ay_s2, az_s2;
	logic [SQ_W-1:0]    sx_s3, sy_s3, sz_s3;
	logic [SUM_W-1:0]   best_q;
	logic [SUM_W-1:0]   sum;

	logic               out_valid_q;
	logic [DIST_W-1:0]  dist_q;
	logic [STAT_W-1:0]  stat_q;
	logic [CNT_W-1:0]   total_q;

	logic               is_full;
	logic               root_done;
	logic [ROOT_W-1:0]  root;

	function automatic logic [MAG_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
	                                              input logic [COORD_W-1:0] b);
		logic [COORD_W:0] d;
		d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
		if (d[COORD_W])
			d = -d;
		return d[MAG_W-1:0];
	endfunction

	assign is_full = (count_q == CNT_W'(MAX_POINTS));

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				if (req_type == REQ_APPEND && !is_full)
					count_q <= count_q + 1'b1;
				else if (req_type == REQ_CLEAR)
					count_q <= '0;
			end
			v_s1 <= cmd.scan_issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (cmd.finish)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// point memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.accept && req_type == REQ_APPEND && !is_full)
			mem[count_q[ADDR_W-1:0]] <= {x_coord, y_coord, z_coord};
		if (cmd.scan_issue)
			pt_s1 <= mem[scan_idx_q];
	end

	// request capture, scan pipeline and running minimum
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			qx_q        <= x_coord;
			qy_q        <= y_coord;
			qz_q        <= z_coord;
			scan_idx_q  <= '0;
			pend_dist_q <= '0;
			if (req_type == REQ_APPEND && is_full)
				pend_stat_q <= ST_FULL;
			else if (req_type == REQ_QUERY && count_q == '0)
				pend_stat_q <= ST_EMPTY;
			else
				pend_stat_q <= ST_OK;
		end else if (cmd.scan_issue) begin
			scan_idx_q <= scan_idx_q + 1'b1;
		end
		if (root_done)
			pend_dist_q <= root;

		first_s1 <= (scan_idx_q == '0);
		first_s2 <= first_s1;
		first_s3 <= first_s2;

		ax_s2 <= abs_diff(pt_s1[3*COORD_W-1 -: COORD_W], qx_q);
		ay_s2 <= abs_diff(pt_s1[2*COORD_W-1 -: COORD_W], qy_q);
		az_s2 <= abs_diff(pt_s1[COORD_W-1:0], qz_q);

		sx_s3 <= ax_s2 * ax_s2;
		sy_s3 <= ay_s2 * ay_s2;
		sz_s3 <= az_s2 * az_s2;

		if (v_s3 && (first_s3 || sum < best_q))
			best_q <= sum;

		if (cmd.finish) begin
			dist_q  <= DIST_W'(pend_dist_q);
			stat_q  <= pend_stat_q;
			total_q <= count_q;
		end
	end

	assign sum = SUM_W'(sx_s3) + SUM_W'(sy_s3) + SUM_W'(sz_s3);

	npd_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.root_start),
		.radicand (best_q),
		.done     (root_done),
		.root     (root)
	);

	assign stat.count_zero = (count_q == '0);
	assign stat.last_issue = ({1'b0, scan_idx_q} == count_q - 1'b1);
	assign stat.pipe_busy  = v_s1 | v_s2 | v_s3;
	assign stat.root_done  = root_done;
	assign stat.out_free   = !out_valid_q || !out_stall;

	assign out_valid   = out_valid_q;
	assign distance    = dist_q;
	assign status      = stat_q;
	assign point_total = total_q;

endmodule

@@ hdl/nearest_point_distance.sv @@
`timescale 1ns / 1ps
// nearest_point_distance: top level of the point store / nearest distance block.
// Depends on npd_pkg, npd_ctrl, npd_dpath (npd_sqrt below it).
//
//  channel | handshake           | payload
//  --------+---------------------+------------------------------------------
//  in      | in_valid / in_stall | req_type, x_coord, y_coord, z_coord
//  out     | out_valid/out_stall | distance, status, point_total
//
// Append, clear, unused codes and empty-store queries go straight to the
// done state, which loads the result into the output register. A query over
// N stored points makes one memory read per point through a 3-stage
// difference/square/compare pipeline, then a bit-serial square root.
// Reset clears the point count; memory contents need no clearing.
// A new input transfer is taken while an earlier result still waits on
// out_stall; the next result is held until the output register frees.
module nearest_point_distance (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic        [npd_pkg::REQ_W-1:0]   req_type,
	input  logic signed [npd_pkg::COORD_W-1:0] x_coord,
	input  logic signed [npd_pkg::COORD_W-1:0] y_coord,
	input  logic signed [npd_pkg::COORD_W-1:0] z_coord,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic        [npd_pkg::DIST_W-1:0]  distance,
	output logic        [npd_pkg::STAT_W-1:0]  status,
	output logic        [npd_pkg::CNT_W-1:0]   point_total
);
	import npd_pkg::*;

	npd_cmd_t  cmd;    // sequencer -> datapath
	npd_stat_t stat;   // datapath -> sequencer

	// sequencer: idle / scan / drain / root / done
	npd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.req_type (req_type),
		.stat     (stat),
		.cmd      (cmd),
		.in_stall (in_stall)
	);

	// memory, scan pipeline, minimum, square root and output register
	npd_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.req_type    (req_type),
		.x_coord     (x_coord),
		.y_coord     (y_coord),
		.z_coord     (z_coord),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.distance    (distance),
		.status      (status),
		.point_total (point_total)
	);

endmodule
